// ----- src/psc_pkg.sv -----
// Package for the pressure sensor compensation unit.
// Holds calibration register codes, fixed constants and the side-band item type.
// No dependencies.
package psc_pkg;

    localparam int RawW    = 20;
    localparam int CfgW    = 64;
    localparam int DivW    = 64;

    localparam logic [33:0] FineOffset = 34'd128000;
    localparam logic [63:0] PressFull  = 64'd1048576;
    localparam logic [63:0] PressScale = 64'd3125;
    localparam logic [31:0] RoundTemp  = 32'd128;
    localparam logic [31:0] TempMul    = 32'd5;
    localparam logic [63:0] P1Bias     = 64'h0000_8000_0000_0000;

    typedef enum logic [1:0] {
        CFG_TEMP    = 2'd0,
        CFG_PRESS_A = 2'd1,
        CFG_PRESS_B = 2'd2,
        CFG_PRESS_C = 2'd3
    } cfg_index_t;

    // temperature results and zero-divisor flag travelling beside the pressure path
    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] fine_temp;
        logic        divisor_zero;
    } side_t;

endpackage

// ----- src/psc_div.sv -----
// Pipelined unsigned 64-bit restoring divider, one quotient bit per stage.
// Applies the result sign on output; carries a side-band item alongside.
// Depends on psc_pkg.
module psc_div
    import psc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [DivW-1:0] in_num,
    input  logic [DivW-1:0] in_den,
    input  logic            in_neg,
    input  side_t           in_side,
    output logic            out_valid,
    output logic [DivW-1:0] out_quot,
    output side_t           out_side
);

    logic [DivW:0]   vld_reg;
    logic [DivW-1:0] rem_reg  [0:DivW];
    logic [DivW-1:0] num_reg  [0:DivW];
    logic [DivW-1:0] den_reg  [0:DivW];
    logic [DivW-1:0] quo_reg  [0:DivW];
    logic            neg_reg  [0:DivW];
    side_t           side_reg [0:DivW];

    logic            out_valid_reg;
    logic [DivW-1:0] out_quot_reg;
    side_t           out_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= {vld_reg[DivW-1:0], in_valid};
            out_valid_reg <= vld_reg[DivW];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        num_reg[0]  <= in_num;
        den_reg[0]  <= in_den;
        quo_reg[0]  <= '0;
        neg_reg[0]  <= in_neg;
        side_reg[0] <= in_side;
    end

    genvar i;
    generate
        for (i = 0; i < DivW; i++)
        begin : g_stage
            logic [DivW-1:0] rem_sh;
            logic            ge;

            assign rem_sh = {rem_reg[i][DivW-2:0], num_reg[i][DivW-1]};
            assign ge     = (rem_sh >= den_reg[i]);

            always_ff @(posedge clk)
            begin
                rem_reg[i+1]  <= ge ? (rem_sh - den_reg[i]) : rem_sh;
                num_reg[i+1]  <= {num_reg[i][DivW-2:0], 1'b0};
                den_reg[i+1]  <= den_reg[i];
                quo_reg[i+1]  <= {quo_reg[i][DivW-2:0], ge};
                neg_reg[i+1]  <= neg_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        out_quot_reg <= neg_reg[DivW] ? (DivW'(0) - quo_reg[DivW]) : quo_reg[DivW];
        out_side_reg <= side_reg[DivW];
    end

    assign out_valid = out_valid_reg;
    assign out_quot  = out_quot_reg;
    assign out_side  = out_side_reg;

endmodule

// ----- src/pressure_sensor_compensation_unit.sv -----
// Top level of the pressure sensor compensation unit: calibration registers,
// temperature and pressure datapath pipeline. Depends on psc_pkg and psc_div.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------------
//  input    | start & !busy       | raw_temp, raw_press
//  result   | done (one cycle)    | temp_centi, fine_temp, press_q24_8, divisor_zero
//  config   | cfg_we              | cfg_index, cfg_data
//
// One item per cycle; each result passes through 10 stages
// before the divider, 66 in it (input register, 64 quotient stages, output
// register) and 4 after it. busy is always low.
// Reset clears valid bits and calibration registers; the receiver cannot stall.
module pressure_sensor_compensation_unit
    import psc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [RawW-1:0]  raw_temp,
    input  logic [RawW-1:0]  raw_press,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  logic [CfgW-1:0]  cfg_data,
    output logic             done,
    output logic [31:0]      temp_centi,
    output logic [31:0]      fine_temp,
    output logic [31:0]      press_q24_8,
    output logic             divisor_zero
);

    logic [47:0] temp_calib_reg;
    logic [63:0] press_calib_a_reg;
    logic [63:0] press_calib_b_reg;
    logic [15:0] press_calib_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg    <= '0;
            press_calib_a_reg <= '0;
            press_calib_b_reg <= '0;
            press_calib_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEMP:    temp_calib_reg    <= cfg_data[47:0];
                CFG_PRESS_A: press_calib_a_reg <= cfg_data;
                CFG_PRESS_B: press_calib_b_reg <= cfg_data;
                CFG_PRESS_C: press_calib_c_reg <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    logic [31:0]        t1, t2, t3;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic [15:0]        p1;

    assign t1 = {16'd0, temp_calib_reg[15:0]};
    assign t2 = {{16{temp_calib_reg[31]}}, temp_calib_reg[31:16]};
    assign t3 = {{16{temp_calib_reg[47]}}, temp_calib_reg[47:32]};
    assign p1 = press_calib_a_reg[15:0];
    assign p2 = press_calib_a_reg[31:16];
    assign p3 = press_calib_a_reg[47:32];
    assign p4 = press_calib_a_reg[63:48];
    assign p5 = press_calib_b_reg[15:0];
    assign p6 = press_calib_b_reg[31:16];
    assign p7 = press_calib_b_reg[47:32];
    assign p8 = press_calib_b_reg[63:48];
    assign p9 = press_calib_c_reg;

    assign busy = 1'b0;

    logic [10:1]     vld_reg;
    logic [RawW-1:0] ap_reg [1:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[9:1], start & ~busy};
    end

    always_ff @(posedge clk)
    begin
        ap_reg[1] <= raw_press;
        for (int k = 2; k <= 8; k++)
            ap_reg[k] <= ap_reg[k-1];
    end

    // stage 1: temperature products
    logic [31:0] x1, dt, s1_ma_next, s1_dd_next;
    logic [31:0] s1_ma_reg, s1_dd_reg;

    assign x1         = {15'd0, raw_temp[19:3]} - {t1[30:0], 1'b0};
    assign dt         = {16'd0, raw_temp[19:4]} - t1;
    assign s1_ma_next = x1 * t2;
    assign s1_dd_next = dt * dt;

    // stage 2
    logic [31:0] s2_a_next, dd_sh, s2_b_next;
    logic [31:0] s2_a_reg, s2_b_reg;

    assign s2_a_next = $signed(s1_ma_reg) >>> 11;
    assign dd_sh     = $signed(s1_dd_reg) >>> 12;
    assign s2_b_next = dd_sh * t3;

    // stage 3: fine temperature
    logic [31:0] s3_tf_next, s3_tf_reg;
    assign s3_tf_next = s2_a_reg + 32'($signed(s2_b_reg) >>> 14);

    // stage 4
    logic [31:0]        tc_sum;
    logic [31:0]        s4_tc_next;
    logic signed [33:0] s4_v1_next, s4_v1_reg;
    side_t              sd_reg [4:10];

    assign tc_sum     = s3_tf_reg * TempMul + RoundTemp;
    assign s4_tc_next = $signed(tc_sum) >>> 8;
    assign s4_v1_next = $signed({{2{s3_tf_reg[31]}}, s3_tf_reg} - FineOffset);

    // stage 5
    logic signed [67:0] vv_full;
    logic signed [49:0] v1p5_next, v1p2_next;
    logic [63:0]        s5_vv_reg;
    logic signed [49:0] s5_v1p5_reg, s5_v1p2_reg;

    assign vv_full   = s4_v1_reg * s4_v1_reg;
    assign v1p5_next = s4_v1_reg * p5;
    assign v1p2_next = s4_v1_reg * p2;

    // stage 6
    logic signed [79:0] t6_full, t3_full;
    logic [63:0]        s6_t6_reg, s6_t3_reg;
    logic signed [49:0] s6_v1p5_reg, s6_v1p2_reg;

    assign t6_full = $signed(s5_vv_reg) * p6;
    assign t3_full = $signed(s5_vv_reg) * p3;

    // stage 7
    logic [63:0] v1p5_64, v1p2_64, p4_64, s7_v2_next, s7_v1_next;
    logic [63:0] s7_v2_reg, s7_v1_reg;

    assign v1p5_64    = {{14{s6_v1p5_reg[49]}}, s6_v1p5_reg};
    assign v1p2_64    = {{14{s6_v1p2_reg[49]}}, s6_v1p2_reg};
    assign p4_64      = {{48{p4[15]}}, p4};
    assign s7_v2_next = s6_t6_reg + (v1p5_64 << 17) + (p4_64 << 35);
    assign s7_v1_next = 64'($signed(s6_t3_reg) >>> 8) + (v1p2_64 << 12);

    // stage 8
    logic [63:0] bias_sum;
    logic [79:0] m1_full;
    logic [63:0] s8_m1_reg, s8_v2_reg;

    assign bias_sum = P1Bias + s7_v1_reg;
    assign m1_full  = bias_sum * p1;

    // stage 9: divisor and numerator
    logic [63:0] s9_d_next, pf, s9_num_next;
    logic [63:0] s9_d_reg, s9_num_reg;

    assign s9_d_next   = $signed(s8_m1_reg) >>> 33;
    assign pf          = PressFull - {44'd0, ap_reg[8]};
    assign s9_num_next = (pf << 31) - s8_v2_reg;

    // stage 10
    logic [63:0] s10_nm_reg, s10_d_reg;

    always_ff @(posedge clk)
    begin
        s1_ma_reg   <= s1_ma_next;
        s1_dd_reg   <= s1_dd_next;
        s2_a_reg    <= s2_a_next;
        s2_b_reg    <= s2_b_next;
        s3_tf_reg   <= s3_tf_next;
        s4_v1_reg   <= s4_v1_next;
        sd_reg[4]   <= '{temp_centi: s4_tc_next, fine_temp: s3_tf_reg, divisor_zero: 1'b0};
        s5_vv_reg   <= vv_full[63:0];
        s5_v1p5_reg <= v1p5_next;
        s5_v1p2_reg <= v1p2_next;
        sd_reg[5]   <= sd_reg[4];
        s6_t6_reg   <= t6_full[63:0];
        s6_t3_reg   <= t3_full[63:0];
        s6_v1p5_reg <= s5_v1p5_reg;
        s6_v1p2_reg <= s5_v1p2_reg;
        sd_reg[6]   <= sd_reg[5];
        s7_v2_reg   <= s7_v2_next;
        s7_v1_reg   <= s7_v1_next;
        sd_reg[7]   <= sd_reg[6];
        s8_m1_reg   <= m1_full[63:0];
        s8_v2_reg   <= s7_v2_reg;
        sd_reg[8]   <= sd_reg[7];
        s9_d_reg    <= s9_d_next;
        s9_num_reg  <= s9_num_next;
        sd_reg[9]   <= '{temp_centi: sd_reg[8].temp_centi,
                         fine_temp: sd_reg[8].fine_temp,
                         divisor_zero: (s9_d_next == '0)};
        s10_nm_reg  <= s9_num_reg * PressScale;
        s10_d_reg   <= s9_d_reg;
        sd_reg[10]  <= sd_reg[9];
    end

    // division on magnitudes
    logic [63:0] an, ad;
    logic        qneg;
    logic        dq_valid;
    logic [63:0] dq;
    side_t       dside;

    assign an   = s10_nm_reg[63] ? (64'd0 - s10_nm_reg) : s10_nm_reg;
    assign ad   = s10_d_reg[63]  ? (64'd0 - s10_d_reg)  : s10_d_reg;
    assign qneg = s10_nm_reg[63] ^ s10_d_reg[63];

    psc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[10]),
        .in_num    (an),
        .in_den    (ad),
        .in_neg    (qneg),
        .in_side   (sd_reg[10]),
        .out_valid (dq_valid),
        .out_quot  (dq),
        .out_side  (dside)
    );

    logic [15:12] pv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else
            pv_reg <= {pv_reg[14:12], dq_valid};
    end

    // stage 12
    logic [63:0]        q13;
    logic signed [79:0] pq_full, p8p_full;
    logic [63:0]        s12_p_reg, s12_q_reg, s12_pq_reg, s12_p8p_reg;
    side_t              s12_sd_reg;

    assign q13      = $signed(dq) >>> 13;
    assign pq_full  = p9 * $signed(q13);
    assign p8p_full = p8 * $signed(dq);

    // stage 13: split 64-bit product, low word only
    logic [63:0] s13_ll_reg, s13_p_reg, s13_p8p_reg;
    logic [31:0] s13_c1_reg, s13_c2_reg;
    side_t       s13_sd_reg;

    // stage 14
    logic [63:0] qq, s14_sum_next, s14_sum_reg;
    side_t       s14_sd_reg;

    assign qq           = s13_ll_reg + {s13_c1_reg + s13_c2_reg, 32'd0};
    assign s14_sum_next = s13_p_reg + 64'($signed(qq) >>> 25)
                        + 64'($signed(s13_p8p_reg) >>> 19);

    // stage 15
    logic [63:0] press_next;
    assign press_next = 64'($signed(s14_sum_reg) >>> 8) + ({{48{p7[15]}}, p7} << 4);

    logic [31:0] temp_centi_reg, fine_temp_reg, press_reg;
    logic        zero_reg;

    always_ff @(posedge clk)
    begin
        s12_p_reg      <= dq;
        s12_q_reg      <= q13;
        s12_pq_reg     <= pq_full[63:0];
        s12_p8p_reg    <= p8p_full[63:0];
        s12_sd_reg     <= dside;
        s13_ll_reg     <= s12_pq_reg[31:0] * s12_q_reg[31:0];
        s13_c1_reg     <= s12_pq_reg[31:0] * s12_q_reg[63:32];
        s13_c2_reg     <= s12_pq_reg[63:32] * s12_q_reg[31:0];
        s13_p_reg      <= s12_p_reg;
        s13_p8p_reg    <= s12_p8p_reg;
        s13_sd_reg     <= s12_sd_reg;
        s14_sum_reg    <= s14_sum_next;
        s14_sd_reg     <= s13_sd_reg;
        temp_centi_reg <= s14_sd_reg.temp_centi;
        fine_temp_reg  <= s14_sd_reg.fine_temp;
        zero_reg       <= s14_sd_reg.divisor_zero;
        press_reg      <= s14_sd_reg.divisor_zero ? 32'd0 : press_next[31:0];
    end

    assign done         = pv_reg[15];
    assign temp_centi   = temp_centi_reg;
    assign fine_temp    = fine_temp_reg;
    assign press_q24_8  = press_reg;
    assign divisor_zero = zero_reg;

endmodule
